// ----- hdl/mfvn_pkg.sv -----
// Types and constants shared by the mesh vertex normal block.
`default_nettype none
package mfvn_pkg;

  localparam int IDX_W = 10;
  localparam int POS_W = 24;
  localparam int N_W = 16;
  localparam int D_W = 41;
  localparam int ACC_W = 64;
  localparam int Q_DEPTH = 4;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic RES_FACE = 1'b0;
  localparam logic RES_VERTEX = 1'b1;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [N_W-1:0] norm_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0] kind;
    idx_t vertex_index;
    logic vertex_ok;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
    idx_t corner_a;
    idx_t corner_b;
    idx_t corner_c;
    logic [2:0] corner_ok;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage
`default_nettype wire

// ----- hdl/mfvn_if.sv -----
// Request and result channel interfaces.
`default_nettype none
interface mfvn_req_if;
  import mfvn_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] kind;
  idx_t vertex_index;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;
  idx_t corner_a;
  idx_t corner_b;
  idx_t corner_c;
  modport source(output valid, kind, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b,
                 corner_c, input ready);
  modport sink(input valid, kind, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b,
               corner_c, output ready);
endinterface

interface mfvn_res_if;
  import mfvn_pkg::*;
  logic valid;
  logic ready;
  logic result_kind;
  norm_t normal_x;
  norm_t normal_y;
  norm_t normal_z;
  logic signed [D_W-1:0] plane_d;
  logic zero_length;
  modport source(output valid, result_kind, normal_x, normal_y, normal_z, plane_d, zero_length,
                 input ready);
  modport sink(input valid, result_kind, normal_x, normal_y, normal_z, plane_d, zero_length,
               output ready);
endinterface
`default_nettype wire

// ----- hdl/mfvn_ram.sv -----
// Generic single write port RAM with a registered read port.
`default_nettype none
module mfvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hdl/mfvn_norm.sv -----
// Iterative normalizer: scaling shift, sum of squares, square root and divisions.
`default_nettype none
module mfvn_norm (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mfvn_pkg::acc_t vec [3],
  output logic           done,
  output mfvn_pkg::norm_t n [3],
  output logic           zero
);
  import mfvn_pkg::*;

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ = 3'd2;
  localparam logic [2:0] N_SQL = 3'd3;
  localparam logic [2:0] N_ZCHK = 3'd4;
  localparam logic [2:0] N_SQRT = 3'd5;
  localparam logic [2:0] N_DIVI = 3'd6;
  localparam logic [2:0] N_DIV = 3'd7;

  logic [2:0] state;
  logic [63:0] m [3];
  logic [2:0] sgn;
  logic [1:0] k;
  logic [61:0] prod;
  logic [63:0] sum;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [47:0] rem;
  logic [47:0] dsh;
  logic [14:0] q;
  logic [3:0] qcnt;
  logic [63:0] trial;
  logic ge;
  logic [15:0] qn;
  logic big;

  always_comb begin
    trial = r + bitv;
    ge = rem >= dsh;
    qn = {q, ge};
    big = (m[0][63:31] != '0) || (m[1][63:31] != '0) || (m[2][63:31] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              sgn[i] <= vec[i][ACC_W-1];
              m[i] <= vec[i][ACC_W-1] ? 64'(-vec[i]) : 64'(vec[i]);
            end
            zero <= 1'b0;
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= m[i] >> 1;
            end
          end else begin
            k <= '0;
            sum <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          prod <= m[k][30:0] * m[k][30:0];
          if (k != 2'd0) begin
            sum <= sum + 64'(prod);
          end
          if (k == 2'd2) begin
            state <= N_SQL;
          end else begin
            k <= k + 2'd1;
          end
        end
        N_SQL: begin
          sum <= sum + 64'(prod);
          state <= N_ZCHK;
        end
        N_ZCHK: begin
          if (sum == '0) begin
            for (int i = 0; i < 3; i++) begin
              n[i] <= '0;
            end
            zero <= 1'b1;
            done <= 1'b1;
            state <= N_IDLE;
          end else begin
            v <= sum;
            r <= '0;
            bitv <= 64'd1 << 62;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (v >= trial) begin
            v <= v - trial;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == 64'd1) begin
            k <= '0;
            state <= N_DIVI;
          end
        end
        N_DIVI: begin
          rem <= 48'({m[k][30:0], 15'b0}) + 48'(r[31:0]);
          dsh <= {r[31:0], 16'b0};
          qcnt <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          dsh <= dsh >> 1;
          q <= qn[14:0];
          qcnt <= qcnt + 4'd1;
          if (qcnt == 4'd15) begin
            n[k] <= sgn[k] ? -$signed(qn) : $signed(qn);
            if (k == 2'd2) begin
              done <= 1'b1;
              state <= N_IDLE;
            end else begin
              k <= k + 2'd1;
              state <= N_DIVI;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mfvn_front.sv -----
// Request intake: classifies requests, drops ignored ones and queues the rest.
`default_nettype none
module mfvn_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  mfvn_req_if.sink               request,
  input  mfvn_pkg::back_status_t status,
  input  logic                   pop,
  output logic                   q_valid,
  output mfvn_pkg::cmd_t         q_head
);
  import mfvn_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t queue [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0] count;
  cmd_t cmd;
  logic keep;
  logic accept;

  always_comb begin
    cmd.kind = request.kind;
    cmd.vertex_index = request.vertex_index;
    cmd.vertex_ok = 32'(request.vertex_index) < MAX_VERTICES;
    cmd.pos_x = request.pos_x;
    cmd.pos_y = request.pos_y;
    cmd.pos_z = request.pos_z;
    cmd.corner_a = request.corner_a;
    cmd.corner_b = request.corner_b;
    cmd.corner_c = request.corner_c;
    cmd.corner_ok[0] = 32'(request.corner_a) < MAX_VERTICES;
    cmd.corner_ok[1] = 32'(request.corner_b) < MAX_VERTICES;
    cmd.corner_ok[2] = 32'(request.corner_c) < MAX_VERTICES;
    case (request.kind)
      KIND_LOAD: keep = cmd.vertex_ok;
      KIND_TRI: keep = 1'b1;
      KIND_READ: keep = 1'b1;
      default: keep = 1'b0;
    endcase
    request.ready = !status.clearing && (count != (PW+1)'(Q_DEPTH));
    accept = request.valid && request.ready && keep;
    q_valid = count != '0;
    q_head = queue[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(accept) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mfvn_back.sv -----
// Execution sequencer: vertex tables, cross product, accumulation and result register.
`default_nettype none
module mfvn_back #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  mfvn_pkg::cmd_t         q_head,
  output logic                   pop,
  output mfvn_pkg::back_status_t status,
  mfvn_res_if.source             result
);
  import mfvn_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int PRW = 3 * POS_W;
  localparam int ARW = 3 * ACC_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_PA = 4'd3;
  localparam logic [3:0] S_PB = 4'd4;
  localparam logic [3:0] S_PC = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_MUL = 4'd7;
  localparam logic [3:0] S_ACCRD = 4'd8;
  localparam logic [3:0] S_ACCWR = 4'd9;
  localparam logic [3:0] S_NSTART = 4'd10;
  localparam logic [3:0] S_NORM = 4'd11;
  localparam logic [3:0] S_DOT = 4'd12;
  localparam logic [3:0] S_OUT = 4'd13;

  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  logic [3:0] state;
  cmd_t cmd;
  logic [AW-1:0] clr_addr;
  pos_t pa [3];
  pos_t pb [3];
  pos_t pc [3];
  logic signed [POS_W:0] u [3];
  logic signed [POS_W:0] w [3];
  acc_t cr [3];
  logic signed [2*POS_W+1:0] prod;
  logic [2:0] mstep;
  logic [2:0] ms1;
  logic [1:0] idx;
  logic [1:0] dstep;
  logic signed [N_W+POS_W-1:0] dprod;
  logic signed [D_W-1:0] dacc;
  norm_t nreg [3];
  logic zreg;

  logic pos_wr_en;
  logic [AW-1:0] pos_wr_addr;
  logic [PRW-1:0] pos_wr_data;
  logic [AW-1:0] pos_rd_addr;
  logic [PRW-1:0] pos_rd_data;
  logic acc_wr_en;
  logic [AW-1:0] acc_wr_addr;
  logic [ARW-1:0] acc_wr_data;
  logic [AW-1:0] acc_rd_addr;
  logic [ARW-1:0] acc_rd_data;
  acc_t acc_rd [3];
  pos_t pos_rd [3];
  idx_t cur_corner;
  logic cur_ok;
  logic signed [POS_W:0] ma;
  logic signed [POS_W:0] mb;
  norm_t da;
  pos_t db;
  logic norm_start;
  acc_t norm_vec [3];
  logic norm_done;
  norm_t norm_n [3];
  logic norm_zero;

  mfvn_ram #(.WIDTH(PRW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .wr_en(pos_wr_en), .wr_addr(pos_wr_addr), .wr_data(pos_wr_data),
    .rd_addr(pos_rd_addr), .rd_data(pos_rd_data)
  );

  mfvn_ram #(.WIDTH(ARW), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk(clk), .wr_en(acc_wr_en), .wr_addr(acc_wr_addr), .wr_data(acc_wr_data),
    .rd_addr(acc_rd_addr), .rd_data(acc_rd_data)
  );

  mfvn_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start), .vec(norm_vec),
    .done(norm_done), .n(norm_n), .zero(norm_zero)
  );

  always_comb begin
    acc_rd[0] = acc_rd_data[3*ACC_W-1:2*ACC_W];
    acc_rd[1] = acc_rd_data[2*ACC_W-1:ACC_W];
    acc_rd[2] = acc_rd_data[ACC_W-1:0];
    pos_rd[0] = pos_rd_data[3*POS_W-1:2*POS_W];
    pos_rd[1] = pos_rd_data[2*POS_W-1:POS_W];
    pos_rd[2] = pos_rd_data[POS_W-1:0];

    case (idx)
      2'd0: begin cur_corner = cmd.corner_a; cur_ok = cmd.corner_ok[0]; end
      2'd1: begin cur_corner = cmd.corner_b; cur_ok = cmd.corner_ok[1]; end
      default: begin cur_corner = cmd.corner_c; cur_ok = cmd.corner_ok[2]; end
    endcase

    pop = (state == S_IDLE) && q_valid;
    status.clearing = state == S_CLEAR;

    pos_wr_en = pop && (q_head.kind == KIND_LOAD);
    pos_wr_addr = AW'(q_head.vertex_index);
    pos_wr_data = {q_head.pos_x, q_head.pos_y, q_head.pos_z};
    case (state)
      S_IDLE: pos_rd_addr = AW'(q_head.corner_a);
      S_PA: pos_rd_addr = AW'(cmd.corner_b);
      S_PB: pos_rd_addr = AW'(cmd.corner_c);
      default: pos_rd_addr = AW'(cmd.corner_a);
    endcase

    acc_wr_en = 1'b0;
    acc_wr_addr = AW'(cur_corner);
    acc_wr_data = '0;
    case (state)
      S_CLEAR: begin
        acc_wr_en = 1'b1;
        acc_wr_addr = clr_addr;
      end
      S_IDLE: begin
        acc_wr_en = pos_wr_en;
        acc_wr_addr = AW'(q_head.vertex_index);
      end
      S_ACCWR: begin
        acc_wr_en = 1'b1;
        acc_wr_data = {sat_add(acc_rd[0], cr[0]), sat_add(acc_rd[1], cr[1]),
                       sat_add(acc_rd[2], cr[2])};
      end
      default: acc_wr_en = 1'b0;
    endcase
    acc_rd_addr = (state == S_IDLE) ? AW'(q_head.vertex_index) : AW'(cur_corner);

    norm_start = (state == S_RDWAIT) || (state == S_NSTART);
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (state == S_RDWAIT) ? acc_rd[i] : cr[i];
    end

    case (mstep)
      3'd0: begin ma = w[1]; mb = u[2]; end
      3'd1: begin ma = w[2]; mb = u[1]; end
      3'd2: begin ma = w[2]; mb = u[0]; end
      3'd3: begin ma = w[0]; mb = u[2]; end
      3'd4: begin ma = w[0]; mb = u[1]; end
      3'd5: begin ma = w[1]; mb = u[0]; end
      default: begin ma = '0; mb = '0; end
    endcase
    ms1 = mstep - 3'd1;

    case (dstep)
      2'd0: begin da = nreg[0]; db = pa[0]; end
      2'd1: begin da = nreg[1]; db = pa[1]; end
      2'd2: begin da = nreg[2]; db = pa[2]; end
      default: begin da = '0; db = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_VERTICES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_head;
            case (q_head.kind)
              KIND_TRI: state <= S_PA;
              KIND_READ: begin
                if (q_head.vertex_ok) begin
                  state <= S_RDWAIT;
                end else begin
                  for (int i = 0; i < 3; i++) begin
                    nreg[i] <= '0;
                  end
                  zreg <= 1'b1;
                  dacc <= '0;
                  state <= S_OUT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RDWAIT: state <= S_NORM;
        S_PA: begin
          for (int i = 0; i < 3; i++) begin
            pa[i] <= cmd.corner_ok[0] ? pos_rd[i] : '0;
          end
          state <= S_PB;
        end
        S_PB: begin
          for (int i = 0; i < 3; i++) begin
            pb[i] <= cmd.corner_ok[1] ? pos_rd[i] : '0;
          end
          state <= S_PC;
        end
        S_PC: begin
          for (int i = 0; i < 3; i++) begin
            pc[i] <= cmd.corner_ok[2] ? pos_rd[i] : '0;
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            u[i] <= (POS_W+1)'(pa[i]) - (POS_W+1)'(pb[i]);
            w[i] <= (POS_W+1)'(pa[i]) - (POS_W+1)'(pc[i]);
            cr[i] <= '0;
          end
          mstep <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= ma * mb;
          if (mstep != 3'd0) begin
            if (ms1[0]) begin
              cr[ms1[2:1]] <= cr[ms1[2:1]] - ACC_W'(prod);
            end else begin
              cr[ms1[2:1]] <= cr[ms1[2:1]] + ACC_W'(prod);
            end
          end
          mstep <= mstep + 3'd1;
          if (mstep == 3'd6) begin
            idx <= '0;
            state <= S_ACCRD;
          end
        end
        S_ACCRD: begin
          if (cur_ok) begin
            state <= S_ACCWR;
          end else if (idx == 2'd2) begin
            state <= S_NSTART;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_ACCWR: begin
          if (idx == 2'd2) begin
            state <= S_NSTART;
          end else begin
            idx <= idx + 2'd1;
            state <= S_ACCRD;
          end
        end
        S_NSTART: state <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            for (int i = 0; i < 3; i++) begin
              nreg[i] <= norm_n[i];
            end
            zreg <= norm_zero;
            dacc <= '0;
            dstep <= '0;
            state <= (cmd.kind == KIND_TRI) ? S_DOT : S_OUT;
          end
        end
        S_DOT: begin
          dprod <= da * db;
          if (dstep != 2'd0) begin
            dacc <= dacc + D_W'(dprod);
          end
          dstep <= dstep + 2'd1;
          if (dstep == 2'd3) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!result.valid || result.ready)) begin
      result.result_kind <= (cmd.kind == KIND_READ) ? RES_VERTEX : RES_FACE;
      result.normal_x <= nreg[0];
      result.normal_y <= nreg[1];
      result.normal_z <= nreg[2];
      result.plane_d <= dacc;
      result.zero_length <= zreg;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mesh_face_vertex_normals_top.sv -----
// Top level of the area-weighted mesh face and vertex normal block.
`default_nettype none
// Requests load vertex positions, process triangles or read vertex normals; a
// request queue decouples intake from a sequencer that runs one request at a
// time. A triangle runs table reads, the cross product and an accumulator
// update for each in-range corner, then the normalizer and a plane dot product;
// a read of an in-range vertex runs the normalizer on its accumulator. The
// normalizer dominates each request: a scaling shift, the sum of squares, a
// square root and a division per component. After reset the accumulator memory
// is cleared, during which no request is taken.
module mesh_face_vertex_normals_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  mfvn_req_if.sink    request,
  mfvn_res_if.source  result
);
  import mfvn_pkg::*;

  back_status_t status;
  logic pop;
  logic q_valid;
  cmd_t q_head;

  mfvn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk(clk), .rst(rst), .request(request), .status(status),
    .pop(pop), .q_valid(q_valid), .q_head(q_head)
  );

  mfvn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head),
    .pop(pop), .status(status), .result(result)
  );
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the mesh face and vertex normal block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import mfvn_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int NUM_VERTS = 1024;
  localparam int RANDOM_REQS = 1330;
  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_CYCLES = 500;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  typedef struct {
    logic       kind;
    norm_t      nx;
    norm_t      ny;
    norm_t      nz;
    logic [D_W-1:0] d;
    logic       zero;
  } normal_res_t;

  typedef struct {
    logic [1:0]  kind;
    idx_t        vi;
    pos_t        x;
    pos_t        y;
    pos_t        z;
    idx_t        a;
    idx_t        b;
    idx_t        c;
    bit          typed;
    normal_res_t want;
  } mesh_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit failed = 1'b0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  pos_t vert_x [NUM_VERTS];
  pos_t vert_y [NUM_VERTS];
  pos_t vert_z [NUM_VERTS];
  longint acc_x [NUM_VERTS];
  longint acc_y [NUM_VERTS];
  longint acc_z [NUM_VERTS];
  bit vert_loaded [NUM_VERTS];
  idx_t loaded_list[$];
  normal_res_t pending_normals[$];
  mesh_req_t directed[$];

  mfvn_req_if req_if();
  mfvn_res_if res_if();

  mesh_face_vertex_normals_top dut (
    .clk(clk),
    .rst(rst),
    .request(req_if),
    .result(res_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sat_sum(input longint lhs, input longint rhs);
    logic signed [64:0] s;
    s = {lhs[63], lhs} + {rhs[63], rhs};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_normal(input longint vx, input longint vy, input longint vz,
                                     output longint ox, output longint oy, output longint oz);
    longint unsigned m [3];
    longint unsigned q [3];
    longint sv [3];
    longint unsigned mx, sum, len;
    int s;
    sv[0] = vx;
    sv[1] = vy;
    sv[2] = vz;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = sv[i] < 0 ? 64'd0 - longint'(sv[i]) : sv[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      sum += m[i] * m[i];
    end
    ox = 0;
    oy = 0;
    oz = 0;
    if (sum == 0) return 1'b1;
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) q[i] = (m[i] * 32768 + len) / (2 * len);
    ox = vx < 0 ? -longint'(q[0]) : longint'(q[0]);
    oy = vy < 0 ? -longint'(q[1]) : longint'(q[1]);
    oz = vz < 0 ? -longint'(q[2]) : longint'(q[2]);
    return 1'b0;
  endfunction

  function automatic bit predict_normals(input mesh_req_t r, output normal_res_t o);
    longint p [3][3];
    longint u [3];
    longint w [3];
    longint cr [3];
    longint nx, ny, nz, dd;
    idx_t cn [3];
    o = '{kind: RES_FACE, nx: 0, ny: 0, nz: 0, d: 0, zero: 1'b0};
    case (r.kind)
      KIND_LOAD: begin
        vert_x[r.vi] = r.x;
        vert_y[r.vi] = r.y;
        vert_z[r.vi] = r.z;
        acc_x[r.vi] = 0;
        acc_y[r.vi] = 0;
        acc_z[r.vi] = 0;
        if (!vert_loaded[r.vi]) loaded_list.push_back(r.vi);
        vert_loaded[r.vi] = 1'b1;
        return 1'b0;
      end
      KIND_TRI: begin
        cn[0] = r.a;
        cn[1] = r.b;
        cn[2] = r.c;
        for (int i = 0; i < 3; i++) begin
          p[i][0] = vert_x[cn[i]];
          p[i][1] = vert_y[cn[i]];
          p[i][2] = vert_z[cn[i]];
        end
        for (int i = 0; i < 3; i++) begin
          u[i] = p[0][i] - p[1][i];
          w[i] = p[0][i] - p[2][i];
        end
        cr[0] = w[1] * u[2] - w[2] * u[1];
        cr[1] = w[2] * u[0] - w[0] * u[2];
        cr[2] = w[0] * u[1] - w[1] * u[0];
        for (int i = 0; i < 3; i++) begin
          acc_x[cn[i]] = sat_sum(acc_x[cn[i]], cr[0]);
          acc_y[cn[i]] = sat_sum(acc_y[cn[i]], cr[1]);
          acc_z[cn[i]] = sat_sum(acc_z[cn[i]], cr[2]);
        end
        o.zero = unit_normal(cr[0], cr[1], cr[2], nx, ny, nz);
        dd = o.zero ? 0 : nx * p[0][0] + ny * p[0][1] + nz * p[0][2];
        o.d = dd[D_W-1:0];
      end
      KIND_READ: begin
        o.kind = RES_VERTEX;
        o.zero = unit_normal(acc_x[r.vi], acc_y[r.vi], acc_z[r.vi], nx, ny, nz);
      end
      default: return 1'b0;
    endcase
    o.nx = nx[N_W-1:0];
    o.ny = ny[N_W-1:0];
    o.nz = nz[N_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_request(input mesh_req_t r);
    normal_res_t o;
    req_if.valid <= 1'b1;
    req_if.kind <= r.kind;
    req_if.vertex_index <= r.vi;
    req_if.pos_x <= r.x;
    req_if.pos_y <= r.y;
    req_if.pos_z <= r.z;
    req_if.corner_a <= r.a;
    req_if.corner_b <= r.b;
    req_if.corner_c <= r.c;
    do @(posedge clk); while (!req_if.ready);
    if (predict_normals(r, o)) pending_normals.push_back(r.typed ? r.want : o);
    if (!calm && $urandom_range(99) < 26) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic mesh_req_t mk_req(input logic [1:0] kind, input idx_t vi, input pos_t x,
                                       input pos_t y, input pos_t z, input idx_t a,
                                       input idx_t b, input idx_t c);
    mesh_req_t r;
    r.kind = kind;
    r.vi = vi;
    r.x = x;
    r.y = y;
    r.z = z;
    r.a = a;
    r.b = b;
    r.c = c;
    r.typed = 1'b0;
    r.want = '{kind: RES_FACE, nx: 0, ny: 0, nz: 0, d: 0, zero: 1'b0};
    return r;
  endfunction

  function automatic mesh_req_t with_result(input mesh_req_t r, input logic kind,
                                            input norm_t nz, input logic zero);
    r.typed = 1'b1;
    r.want = '{kind: kind, nx: 0, ny: 0, nz: nz, d: 0, zero: zero};
    return r;
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? POS_MAX : POS_MIN;
      1: return pos_t'($signed($urandom_range(40000)) - 20000);
      default: return pos_t'($urandom());
    endcase
  endfunction

  function automatic idx_t rand_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  function automatic idx_t rand_vertex();
    if (loaded_list.size() > 0 && $urandom_range(99) < 70) return rand_loaded();
    return idx_t'($urandom());
  endfunction

  function automatic mesh_req_t rand_request();
    int pick;
    pick = $urandom_range(99);
    if (loaded_list.size() < 3 || pick < 28)
      return mk_req(KIND_LOAD, $urandom_range(99) < 60 ? idx_t'($urandom_range(63))
                    : idx_t'($urandom()), rand_pos(), rand_pos(), rand_pos(),
                    idx_t'($urandom()), idx_t'($urandom()), idx_t'($urandom()));
    if (pick < 75)
      return mk_req(KIND_TRI, idx_t'($urandom()), pos_t'($urandom()), pos_t'($urandom()),
                    pos_t'($urandom()), rand_loaded(), rand_loaded(), rand_loaded());
    if (pick < 95)
      return mk_req(KIND_READ, rand_vertex(), pos_t'($urandom()), pos_t'($urandom()),
                    pos_t'($urandom()), idx_t'($urandom()), idx_t'($urandom()),
                    idx_t'($urandom()));
    return mk_req(KIND_NONE, idx_t'($urandom()), pos_t'($urandom()), pos_t'($urandom()),
                  pos_t'($urandom()), idx_t'($urandom()), idx_t'($urandom()),
                  idx_t'($urandom()));
  endfunction

  initial begin
    res_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || $urandom_range(99) >= 26;
    end
  end

  always @(posedge clk) begin
    normal_res_t e;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: result with nothing expected, got kind %0d n %0d %0d %0d d %0d z %0d",
                 $time, res_if.result_kind, res_if.normal_x, res_if.normal_y,
                 res_if.normal_z, res_if.plane_d, res_if.zero_length);
        failed = 1'b1;
      end else begin
        e = pending_normals.pop_front();
        if (res_if.result_kind !== e.kind || res_if.normal_x !== e.nx ||
            res_if.normal_y !== e.ny || res_if.normal_z !== e.nz ||
            res_if.plane_d !== e.d || res_if.zero_length !== e.zero) begin
          $display("%0t: mismatch expected kind %0d n %0d %0d %0d d %0d z %0d", $time,
                   e.kind, e.nx, e.ny, e.nz, $signed(e.d), e.zero);
          $display("%0t:          actual   kind %0d n %0d %0d %0d d %0d z %0d", $time,
                   res_if.result_kind, res_if.normal_x, res_if.normal_y, res_if.normal_z,
                   res_if.plane_d, res_if.zero_length);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL mesh_face_vertex_normals_top");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.kind = KIND_LOAD;
    req_if.vertex_index = '0;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.pos_z = '0;
    req_if.corner_a = '0;
    req_if.corner_b = '0;
    req_if.corner_c = '0;
    for (int i = 0; i < NUM_VERTS; i++) begin
      acc_x[i] = 0;
      acc_y[i] = 0;
      acc_z[i] = 0;
      vert_loaded[i] = 1'b0;
    end

    directed.push_back(with_result(mk_req(KIND_READ, 10'd5, 0, 0, 0, 0, 0, 0),
                                   RES_VERTEX, 0, 1'b1));
    directed.push_back(with_result(mk_req(KIND_READ, 10'd1023, 0, 0, 0, 0, 0, 0),
                                   RES_VERTEX, 0, 1'b1));
    directed.push_back(mk_req(KIND_NONE, 10'd1023, POS_MAX, POS_MIN, -1, 10'd1023, 0,
                              10'd682));
    directed.push_back(mk_req(KIND_LOAD, 10'd0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_req(KIND_LOAD, 10'd1, 24'sd4096, 0, 0, 0, 0, 0));
    directed.push_back(mk_req(KIND_LOAD, 10'd2, 0, 24'sd4096, 0, 0, 0, 0));
    directed.push_back(with_result(mk_req(KIND_TRI, 0, 0, 0, 0, 10'd0, 10'd1, 10'd2),
                                   RES_FACE, -16'sd16384, 1'b0));
    directed.push_back(with_result(mk_req(KIND_READ, 10'd0, 0, 0, 0, 0, 0, 0),
                                   RES_VERTEX, -16'sd16384, 1'b0));
    directed.push_back(with_result(mk_req(KIND_TRI, 0, 0, 0, 0, 10'd1, 10'd1, 10'd1),
                                   RES_FACE, 0, 1'b1));
    directed.push_back(mk_req(KIND_LOAD, 10'd1023, POS_MAX, POS_MAX, POS_MAX, 0, 0, 0));
    directed.push_back(mk_req(KIND_LOAD, 10'd512, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    directed.push_back(mk_req(KIND_LOAD, 10'd341, POS_MAX, POS_MIN, 0, 0, 0, 0));
    directed.push_back(mk_req(KIND_LOAD, 10'd682, POS_MIN, 0, POS_MAX, 0, 0, 0));
    directed.push_back(mk_req(KIND_TRI, 0, 0, 0, 0, 10'd1023, 10'd512, 10'd341));
    directed.push_back(mk_req(KIND_TRI, 0, 0, 0, 0, 10'd341, 10'd682, 10'd1023));
    directed.push_back(mk_req(KIND_TRI, 0, 0, 0, 0, 10'd682, 10'd512, 10'd341));
    directed.push_back(mk_req(KIND_READ, 10'd1023, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_req(KIND_READ, 10'd341, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_req(KIND_READ, 10'd682, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_req(KIND_LOAD, 10'd341, -1, 24'sd1, -1, 0, 0, 0));
    directed.push_back(with_result(mk_req(KIND_READ, 10'd341, 0, 0, 0, 0, 0, 0),
                                   RES_VERTEX, 0, 1'b1));
    directed.push_back(mk_req(KIND_TRI, 0, 0, 0, 0, 10'd341, 10'd2, 10'd1023));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_request(directed[i]);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 300) hold_go = 1'b1;
      if (n == 600) begin
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending_normals.size() > 0);
      end
      calm = n >= 800 && n < 1000;
      send_request(rand_request());
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    while (pending_normals.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("PASS mesh_face_vertex_normals_top");
    end else begin
      $display("FAIL mesh_face_vertex_normals_top");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/mfvn_pkg.sv
hdl/mfvn_if.sv
hdl/mfvn_ram.sv
hdl/mfvn_norm.sv
hdl/mfvn_front.sv
hdl/mfvn_back.sv
hdl/mesh_face_vertex_normals_top.sv
verif/tb_top.sv
